>>> rtl/hra_pkg.sv
`timescale 1ns / 1ps

package hra_pkg;

  // Store geometry
  localparam int unsigned POSITIONS = 1024;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OFF_W     = $clog2(WORD_W);
  localparam int unsigned NWORDS    = (POSITIONS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned SCAN_W    = ADDR_W + OFF_W;

  // Field widths
  localparam int unsigned POS_W = 10;
  localparam int unsigned LEN_W = 11;

  // Arithmetic width for slot sums and range compares
  localparam int unsigned EXT_W = ((SCAN_W > LEN_W) ? SCAN_W : LEN_W) + 2;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NWORDS - 1);

  // Valid bits in the last word; the rest lie past the store and count as busy
  localparam int unsigned TAIL_BITS = POSITIONS - (NWORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK = WORD_W'((65'd1 << TAIL_BITS) - 65'd1);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] position;
    logic [LEN_W-1:0] length;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] run_start;
    logic [POS_W-1:0] run_end;
    logic             ok;
  } out_t;

  // Word scan results
  typedef struct packed {
    logic              free_found;  // free slot at or after the offset
    logic [OFF_W-1:0]  free_off;
    logic              stop_found;  // run stops inside this word
    logic [OFF_W-1:0]  stop_off;    // first slot that is not claimed
    logic [WORD_W-1:0] run_mask;    // slots to claim in this word
    logic              lim_beyond;  // run limit lies in a later word
  } scan_t;

endpackage

>>> rtl/hinted_run_allocator_core.sv
`timescale 1ns / 1ps
// Channel | Valid      | Stall      | Payload           | Dir
// input   | in_valid_i | in_stall_o | in_data_i  (in_t) | in
// output  | out_valid_o| out_stall_i| out_data_o (out_t)| out
//
// One transaction at a time. A free reads its word and writes it back. An allocate
// scans bitmap words from the hint for a free slot, then claims the words the run
// spans (none if no slot is free), writing each claimed word back.
// Reset clears the bitmap at once through per-word valid bits; no sweep.
// A finished result sits in the output register, so a stalled output blocks
// input only once the next allocate has its result ready.

module hinted_run_allocator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hra_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hra_pkg::out_t out_data_o
);
  import hra_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIND   = 5'b00010,
    ST_CLAIM  = 5'b00100,
    ST_FREE   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [LEN_W-1:0]  want_q, want_d;
  logic [SCAN_W-1:0] start_q, start_d;
  logic [SCAN_W-1:0] end_q, end_d;
  logic [SCAN_W-1:0] limit_q, limit_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              first_q, first_d;
  logic              res_ok_q, res_ok_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_data_q, out_data_d;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [WORD_W-1:0] scan_word;
  scan_t             scan;

  logic [EXT_W-1:0]  hint_ext;
  logic              hint_ok;
  logic [EXT_W-1:0]  lim_sum;
  logic [EXT_W-1:0]  start_ext;
  logic [EXT_W-1:0]  end_ext;
  logic              out_load;

  hra_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // first claim reuses the word found during the search
  assign scan_word = (state_q == ST_CLAIM && first_q) ? word_q : rd_data;

  hra_scan u_scan (
    .word_i  (scan_word),
    .addr_i  (addr_q),
    .off_i   (off_q),
    .limit_i (limit_q),
    .scan_o  (scan)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign hint_ext   = EXT_W'(in_data_i.position);
  assign hint_ok    = (hint_ext < EXT_W'(POSITIONS));

  assign lim_sum = EXT_W'({addr_q, scan.free_off}) + EXT_W'(want_q) - EXT_W'(1);

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    off_d    = off_q;
    want_d   = want_q;
    start_d  = start_q;
    end_d    = end_q;
    limit_d  = limit_q;
    word_d   = word_q;
    first_d  = first_q;
    res_ok_d = res_ok_q;
    rd_en    = 1'b0;
    rd_addr  = addr_q;
    wr_en    = 1'b0;
    wr_addr  = addr_q;
    wr_data  = rd_data;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          addr_d = hint_ext[OFF_W +: ADDR_W];
          off_d  = hint_ext[OFF_W-1:0];
          want_d = (in_data_i.length == '0) ? LEN_W'(1) : in_data_i.length;
          if (hint_ok) begin
            rd_en   = 1'b1;
            rd_addr = hint_ext[OFF_W +: ADDR_W];
          end
          if (in_data_i.func == FUNC_FREE) begin
            state_d = hint_ok ? ST_FREE : ST_IDLE;
          end else if (hint_ok) begin
            state_d = ST_FIND;
          end else begin
            res_ok_d = 1'b0;
            state_d  = ST_RESULT;
          end
        end
      end
      ST_FIND: begin
        if (scan.free_found) begin
          start_d = {addr_q, scan.free_off};
          end_d   = {addr_q, scan.free_off};
          off_d   = scan.free_off;
          word_d  = rd_data;
          first_d = 1'b1;
          if (lim_sum > EXT_W'(POSITIONS - 1)) begin
            limit_d = SCAN_W'(POSITIONS - 1);
          end else begin
            limit_d = lim_sum[SCAN_W-1:0];
          end
          state_d = ST_CLAIM;
        end else if (addr_q == LAST_ADDR) begin
          res_ok_d = 1'b0;
          state_d  = ST_RESULT;
        end else begin
          addr_d  = addr_q + ADDR_W'(1);
          off_d   = '0;
          rd_en   = 1'b1;
          rd_addr = addr_q + ADDR_W'(1);
        end
      end
      ST_CLAIM: begin
        wr_en   = 1'b1;
        wr_data = scan_word | scan.run_mask;
        if (!scan.stop_found) begin
          end_d = {addr_q, {OFF_W{1'b1}}};
        end else if (scan.stop_off != off_q) begin
          end_d = {addr_q, scan.stop_off - OFF_W'(1)};
        end
        if (!scan.stop_found && scan.lim_beyond) begin
          addr_d  = addr_q + ADDR_W'(1);
          off_d   = '0;
          first_d = 1'b0;
          rd_en   = 1'b1;
          rd_addr = addr_q + ADDR_W'(1);
        end else begin
          res_ok_d = 1'b1;
          state_d  = ST_RESULT;
        end
      end
      ST_FREE: begin
        wr_en   = 1'b1;
        wr_data = rd_data & ~(WORD_W'(1) << off_q);
        state_d = ST_IDLE;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign start_ext = EXT_W'(start_q);
  assign end_ext   = EXT_W'(end_q);

  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d          = 1'b1;
      out_data_d.ok        = res_ok_q;
      out_data_d.run_start = res_ok_q ? start_ext[POS_W-1:0] : '0;
      out_data_d.run_end   = res_ok_q ? end_ext[POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    off_q      <= off_d;
    want_q     <= want_d;
    start_q    <= start_d;
    end_q      <= end_d;
    limit_q    <= limit_d;
    word_q     <= word_d;
    first_q    <= first_d;
    res_ok_q   <= res_ok_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/hra_bitmap.sv
`timescale 1ns / 1ps

module hra_bitmap (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [hra_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [hra_pkg::WORD_W-1:0]  rd_data_o,
  input  logic                        wr_en_i,
  input  logic [hra_pkg::ADDR_W-1:0]  wr_addr_i,
  input  logic [hra_pkg::WORD_W-1:0]  wr_data_i
);
  import hra_pkg::*;

  logic [WORD_W-1:0] mem_q [NWORDS];
  logic [WORD_W-1:0] rd_data_q;
  logic [NWORDS-1:0] vld_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // A word never written since reset reads as all free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/hra_scan.sv
`timescale 1ns / 1ps

module hra_scan (
  input  logic [hra_pkg::WORD_W-1:0] word_i,
  input  logic [hra_pkg::ADDR_W-1:0] addr_i,
  input  logic [hra_pkg::OFF_W-1:0]  off_i,
  input  logic [hra_pkg::SCAN_W-1:0] limit_i,
  output hra_pkg::scan_t             scan_o
);
  import hra_pkg::*;

  logic [WORD_W-1:0] in_range;
  logic [WORD_W-1:0] free_v;
  logic [WORD_W-1:0] from_m;
  logic [WORD_W-1:0] lim_m;
  logic [WORD_W-1:0] hit_v;
  logic [WORD_W-1:0] stop_v;
  logic [ADDR_W-1:0] lim_addr;
  logic [OFF_W-1:0]  lim_off;
  logic              free_found;
  logic [OFF_W-1:0]  free_off;
  logic              stop_found;
  logic [OFF_W-1:0]  stop_off;
  logic [WORD_W-1:0] run_mask;
  logic              lim_beyond;

  assign lim_addr = limit_i[OFF_W +: ADDR_W];
  assign lim_off  = limit_i[OFF_W-1:0];

  assign in_range = (addr_i == LAST_ADDR) ? TAIL_MASK : '1;
  assign free_v   = ~word_i & in_range;
  assign from_m   = {WORD_W{1'b1}} << off_i;

  always_comb begin
    if (addr_i < lim_addr) begin
      lim_m = '1;
    end else if (addr_i == lim_addr) begin
      lim_m = WORD_W'((65'd2 << lim_off) - 65'd1);
    end else begin
      lim_m = '0;
    end
  end

  assign hit_v  = free_v & from_m;
  assign stop_v = ~(free_v & lim_m) & from_m;

  // lowest set bit of each vector
  always_comb begin
    free_found = 1'b0;
    free_off   = '0;
    stop_found = 1'b0;
    stop_off   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        free_found = 1'b1;
        free_off   = OFF_W'(i);
      end
      if (stop_v[i]) begin
        stop_found = 1'b1;
        stop_off   = OFF_W'(i);
      end
    end
  end

  always_comb begin
    if (stop_found) begin
      run_mask = from_m & WORD_W'((65'd1 << stop_off) - 65'd1);
    end else begin
      run_mask = from_m;
    end
  end

  assign lim_beyond = (lim_addr > addr_i);

  assign scan_o = '{free_found: free_found,
                    free_off:   free_off,
                    stop_found: stop_found,
                    stop_off:   stop_off,
                    run_mask:   run_mask,
                    lim_beyond: lim_beyond};

endmodule

>>> verif/hinted_run_allocator_core_tb.sv
`timescale 1ns / 1ps

module hinted_run_allocator_core_tb;
  import hra_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 2000;
  localparam int DRAIN_CYCLES    = 100;

  // Mirrors the occupancy map and keeps the runs still owed by the block.
  class run_scoreboard;
    bit   busy [POSITIONS];
    out_t runs_due [$];
    int   errors;

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function out_t claim_run(logic [POS_W-1:0] hint, logic [LEN_W-1:0] want);
      int unsigned lo;
      int unsigned hi;
      int unsigned stop;
      out_t        r;
      r  = '0;
      lo = 32'(hint);
      while (lo < POSITIONS && busy[lo]) lo++;
      if (lo >= POSITIONS) return r;
      stop = lo + ((want == '0) ? 32'd1 : 32'(want)) - 32'd1;
      if (stop > POSITIONS - 1) stop = POSITIONS - 1;
      hi = lo;
      while (hi < stop && !busy[hi + 1]) hi++;
      for (int unsigned s = lo; s <= hi; s++) busy[s] = 1'b1;
      r.run_start = lo[POS_W-1:0];
      r.run_end   = hi[POS_W-1:0];
      r.ok        = 1'b1;
      return r;
    endfunction

    function void note_input(in_t t);
      out_t r;
      if (t.func == FUNC_ALLOC) begin
        r        = claim_run(t.position, t.length);
        runs_due = {runs_due, r};
      end else if (32'(t.position) < POSITIONS) begin
        busy[t.position] = 1'b0;
      end
    endfunction

    task check_result(out_t got);
      out_t want;
      if (runs_due.size() == 0) begin
        report($sformatf("result with no request pending: start %0d end %0d ok %0b",
                         got.run_start, got.run_end, got.ok));
        return;
      end
      want = runs_due.pop_front();
      if (got.ok !== want.ok)
        report($sformatf("ok: got %0b, want %0b", got.ok, want.ok));
      if (got.run_start !== want.run_start)
        report($sformatf("run_start: got %0d, want %0d", got.run_start, want.run_start));
      if (got.run_end !== want.run_end)
        report($sformatf("run_end: got %0d, want %0d", got.run_end, want.run_end));
    endtask

    function int pending();
      return runs_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  run_scoreboard sb;
  bit quiet;
  bit hold_req;
  int idle_cycles;
  int rx_wait;

  hinted_run_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (in_valid && !in_stall) sb.note_input(in_data);
    if (out_valid && !out_stall) sb.check_result(out_data);
  end

  // nothing accepted for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic in_t mk(logic f, int pos, int len);
    in_t t;
    t.func     = f;
    t.position = POS_W'(pos);
    t.length   = LEN_W'(len);
    return t;
  endfunction

  // entered and left at a falling edge; valid stays up until the next call
  task automatic send(in_t item);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_phase(int n, int alloc_pct, int max_len);
    in_t item;
    int  slot;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        item.func     = FUNC_ALLOC;
        item.position = POS_W'($urandom);
        item.length   = ($urandom_range(0, 19) == 0) ? LEN_W'($urandom)
                                                     : LEN_W'($urandom_range(0, max_len));
      end else begin
        item.func     = FUNC_FREE;
        item.position = POS_W'($urandom);
        item.length   = LEN_W'($urandom);
        // mostly release a slot that is actually held
        if ($urandom_range(0, 9) < 8) begin
          slot = int'(item.position);
          for (int k = 0; k < POSITIONS; k++) begin
            if (sb.busy[(slot + k) % POSITIONS]) begin
              item.position = POS_W'((slot + k) % POSITIONS);
              break;
            end
          end
        end
      end
      send(item);
    end
  endtask

  // result side
  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end
      rx_wait = quiet ? 0 : $urandom_range(0, 15);
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        repeat (rx_wait) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      @(negedge clk_i);
    end
  end

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(mk(FUNC_ALLOC, 0, 0));         // zero length claims one slot
    send(mk(FUNC_ALLOC, 0, 1));         // hint busy, moves to next free
    send(mk(FUNC_ALLOC, 1020, 2047));   // run cut at end of store
    send(mk(FUNC_ALLOC, 1023, 1));      // nothing free at or after hint
    send(mk(FUNC_ALLOC, 1021, 1024));
    send(mk(FUNC_ALLOC, 3, 2));
    send(mk(FUNC_ALLOC, 0, 1024));      // run stops before occupied slot
    send(mk(FUNC_FREE, 3, 0));
    send(mk(FUNC_FREE, 3, 2047));       // already free
    send(mk(FUNC_ALLOC, 0, 8));
    send(mk(FUNC_FREE, 1023, 5));
    send(mk(FUNC_ALLOC, 1023, 0));
    send(mk(FUNC_ALLOC, 600, 100));
    send(mk(FUNC_FREE, 0, 1365));
    send(mk(FUNC_FREE, 1000, 682));     // already free
    send(mk(FUNC_ALLOC, 682, 1365));
    send(mk(FUNC_ALLOC, 1, 0));
    send(mk(FUNC_ALLOC, 341, 682));
    send(mk(FUNC_ALLOC, 1023, 2047));

    // receiver holds off while the sender keeps pushing
    hold_req = 1'b1;
    quiet    = 1'b1;
    run_phase(60, 60, 16);
    quiet = 1'b0;
    wait_drained();

    run_phase(150, 90, 64);
    run_phase(150, 30, 8);
    quiet = 1'b1;
    run_phase(150, 60, 16);
    quiet = 1'b0;
    wait_drained();
    run_phase(150, 20, 4);
    run_phase(150, 80, 2047);
    run_phase(150, 50, 32);
    run_phase(150, 25, 8);
    run_phase(150, 70, 4);
    run_phase(90, 40, 16);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/hra_pkg.sv
rtl/hra_bitmap.sv
rtl/hra_scan.sv
rtl/hinted_run_allocator_core.sv
verif/hinted_run_allocator_core_tb.sv
